/* rtl/cnmd_pkg.sv */
package cnmd_pkg;

   // Largest supported image; the line memory holds one entry per column.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 3;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WID_W  = 11;
   localparam int HGT_W  = 13;
   localparam int CNT_W  = 3;
   localparam int PIX_W  = 8;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // Result queue depth and its pointer and count widths.
   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = FPTR_W + 1;

   // Register indexes, taken from the word address bit.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(256);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(256);

   typedef enum logic [1:0] {
      KIND_NONE        = 2'd0,
      KIND_UNKNOWN     = 2'd1,
      KIND_ENDPOINT    = 2'd2,
      KIND_BIFURCATION = 2'd3
   } kind_type;

   // Effective (clamped) frame size.
   typedef struct packed {
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } cfg_type;

   // Position and flags of an item on its way from the counters to the classifier.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] center_row;
      logic [COL_W-1:0] center_col;
      logic             emit;
      logic             last;
      logic             cur;
   } pos_type;

   typedef struct packed {
      logic [ROW_W-1:0] center_row;
      logic [COL_W-1:0] center_col;
      logic [CNT_W-1:0] crossing_count;
      kind_type         minutia_kind;
      logic             center_is_ridge;
      logic             frame_last;
   } rsp_type;

endpackage

/* rtl/crossing_number_minutiae_detector_top.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_pixel_value
// rsp       out        rsp_valid/rsp_ready  rsp_center_row, rsp_center_col,
//                                           rsp_crossing_count, rsp_minutia_kind,
//                                           rsp_center_is_ridge, rsp_frame_last
// csr       in/out     APB psel/penable     image_width at 0x0, image_height at 0x4
//
// One pixel item is accepted per cycle while req_ready is high; its result passes the
// second stage register and the result queue before it shows on the rsp channel.
// The line memory has a separate read port and write port. The read for one pixel and
// the write back of the previous pixel can therefore share a cycle.
// After reset, a clearing pass writes zero to all 1024 line memory entries, one per
// cycle; req_ready stays low until the pass is done.
// A four-entry result queue decouples the sides; req_ready drops during the clearing
// pass and when the queue and the item in flight could fill it.
module crossing_number_minutiae_detector_top import cnmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PIX_W-1:0]  req_pixel_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_center_row,
   output logic [COL_W-1:0]  rsp_center_col,
   output logic [CNT_W-1:0]  rsp_crossing_count,
   output logic [1:0]        rsp_minutia_kind,
   output logic              rsp_center_is_ridge,
   output logic              rsp_frame_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   cnmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Clearing pass over the line memory after reset.
   logic             clr_busy_ff;
   logic [COL_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Raster position of the arriving pixel.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W:0]   row_pre;
   logic [ROW_W-1:0] row_cur;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;
   logic             accept;
   pos_type          pos;

   assign accept = req_valid && req_ready;

   always_comb begin
      // A counter left beyond a newly written size wraps before use.
      if (WID_W'(col_ff) >= cfg.width) begin
         col_cur = '0;
         row_pre = (ROW_W + 1)'(row_ff) + 1'b1;
      end else begin
         col_cur = col_ff;
         row_pre = (ROW_W + 1)'(row_ff);
      end
      row_cur = (HGT_W'(row_pre) >= cfg.height) ? '0 : row_pre[ROW_W-1:0];

      col_inc = (COL_W + 1)'(col_cur) + 1'b1;
      row_inc = (ROW_W + 1)'(row_cur) + 1'b1;
      if (WID_W'(col_inc) >= cfg.width) begin
         col_in = '0;
         row_in = (HGT_W'(row_inc) >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end

      pos.col        = col_cur;
      pos.center_row = row_cur - 1'b1;
      pos.center_col = col_cur - 1'b1;
      pos.emit       = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      pos.last       = (HGT_W'(row_cur) == cfg.height - 1'b1) &&
                       (WID_W'(col_cur) == cfg.width - 1'b1);
      pos.cur        = (req_pixel_value != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Second stage: memory data is back, window and write back happen here.
   logic    s1_valid_ff;
   pos_type s1_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff <= pos;
      end
   end

   // Consecutive items always differ in column (the width is at least three), so the
   // write back of one item never meets the read of the next at the same entry.
   logic [1:0]       line_data;
   logic             mem_wr_en;
   logic [COL_W-1:0] mem_wr_addr;
   logic [1:0]       mem_wr_data;

   assign mem_wr_en   = clr_busy_ff || s1_valid_ff;
   assign mem_wr_addr = clr_busy_ff ? clr_addr_ff : s1_pos_ff.col;
   assign mem_wr_data = clr_busy_ff ? 2'b00 : {line_data[0], s1_pos_ff.cur};

   cnmd_line_ram u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (line_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   logic    push;
   rsp_type push_data;

   cnmd_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_pos    (s1_pos_ff),
      .line_data (line_data),
      .push      (push),
      .push_data (push_data)
   );

   rsp_type           head;
   logic [FCNT_W-1:0] fifo_count;
   logic              pop;

   assign pop = rsp_valid && rsp_ready;

   cnmd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (fifo_count)
   );

   // The item in the second stage may still push, so it holds a queue slot.
   assign req_ready = !clr_busy_ff &&
                      ((fifo_count + FCNT_W'(s1_valid_ff)) < FCNT_W'(FIFO_DEPTH));

   assign rsp_center_row      = head.center_row;
   assign rsp_center_col      = head.center_col;
   assign rsp_crossing_count  = head.crossing_count;
   assign rsp_minutia_kind    = head.minutia_kind;
   assign rsp_center_is_ridge = head.center_is_ridge;
   assign rsp_frame_last      = head.frame_last;

endmodule

/* rtl/cnmd_csr.sv */
module cnmd_csr import cnmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic             wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_ff  <= csr_pwdata[WID_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[HGT_W-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Out-of-range sizes are saturated to the supported range.
   always_comb begin
      if (width_ff < WID_W'(MIN_SIZE)) begin
         cfg.width = WID_W'(MIN_SIZE);
      end else if (width_ff > WID_W'(MAX_WIDTH)) begin
         cfg.width = WID_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff < HGT_W'(MIN_SIZE)) begin
         cfg.height = HGT_W'(MIN_SIZE);
      end else if (height_ff > HGT_W'(MAX_HEIGHT)) begin
         cfg.height = HGT_W'(MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
   end

endmodule

/* rtl/cnmd_line_ram.sv */
module cnmd_line_ram import cnmd_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data
);

   // Bit 1 holds the pixel two rows up, bit 0 the pixel one row up.
   logic [1:0] mem_ff [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/cnmd_classify.sv */
module cnmd_classify import cnmd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_valid,
   input  pos_type    s1_pos,
   input  logic [1:0] line_data,
   output logic       push,
   output rsp_type    push_data
);

   logic [8:0] window_ff;
   logic [8:0] window_in;
   logic [7:0] ring;
   logic [7:0] diff;
   logic [3:0] sum;
   logic [CNT_W-1:0] cn;
   logic       centre;

   // Columns move left; the new column is {cur, middle, upper} from bottom to top.
   assign window_in = ((window_ff >> 1) & 9'h0DB) | {s1_pos.cur, 2'b00, line_data[0], 2'b00,
                      line_data[1], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_valid) begin
         window_ff <= window_in;
      end
   end

   // The eight neighbors in ring order, starting at the top left.
   assign ring = {window_in[3], window_in[6], window_in[7], window_in[8],
                  window_in[5], window_in[2], window_in[1], window_in[0]};
   assign diff = ring ^ {ring[6:0], ring[7]};

   always_comb begin
      sum = '0;
      for (int k = 0; k < 8; k++) begin
         sum = sum + 4'(diff[k]);
      end
   end

   assign centre = window_in[4];
   assign cn     = centre ? sum[3:1] : '0;

   always_comb begin
      push_data.center_row      = s1_pos.center_row;
      push_data.center_col      = s1_pos.center_col;
      push_data.crossing_count  = cn;
      push_data.center_is_ridge = centre;
      push_data.frame_last      = s1_pos.last;
      case (cn)
         3'd0:    push_data.minutia_kind = KIND_UNKNOWN;
         3'd1:    push_data.minutia_kind = KIND_ENDPOINT;
         3'd3:    push_data.minutia_kind = KIND_BIFURCATION;
         default: push_data.minutia_kind = KIND_NONE;
      endcase
   end

   assign push = s1_valid && s1_pos.emit;

endmodule

/* rtl/cnmd_rsp_fifo.sv */
module cnmd_rsp_fifo import cnmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_type           push_data,
   input  logic              pop,
   output logic              not_empty,
   output rsp_type           head,
   output logic [FCNT_W-1:0] count
);

   rsp_type             slot_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ptr_ff;
   logic [FPTR_W-1:0]   rd_ptr_ff;
   logic [FCNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + FCNT_W'(push) - FCNT_W'(pop);
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* rtl/cnmd_checker.sv */
module cnmd_checker import cnmd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ROW_W-1:0]  rsp_center_row,
   input logic [COL_W-1:0]  rsp_center_col,
   input logic [CNT_W-1:0]  rsp_crossing_count,
   input logic [1:0]        rsp_minutia_kind,
   input logic              rsp_center_is_ridge,
   input logic              rsp_frame_last
);

   // A stalled result item holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_row) &&
      $stable(rsp_center_col) && $stable(rsp_crossing_count) &&
      $stable(rsp_minutia_kind) && $stable(rsp_center_is_ridge) && $stable(rsp_frame_last))
      else $error("result item changed while stalled");

   // A background center always has crossing number zero and is classed unknown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_center_is_ridge |->
      rsp_crossing_count == '0 && rsp_minutia_kind == KIND_UNKNOWN)
      else $error("background center with nonzero crossing number");

   // Crossing numbers stay within the ring and the class follows the number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_crossing_count <= CNT_W'(4) &&
      ((rsp_crossing_count == CNT_W'(1)) == (rsp_minutia_kind == KIND_ENDPOINT)) &&
      ((rsp_crossing_count == CNT_W'(3)) == (rsp_minutia_kind == KIND_BIFURCATION)))
      else $error("crossing number and class disagree");

   // Reported centers are never in the top row or the left column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_row != '0 && rsp_center_col != '0)
      else $error("border pixel reported");

endmodule

bind crossing_number_minutiae_detector_top cnmd_checker u_cnmd_checker (.*);
